FILE: rtl/fres_pkg.sv
// Shared constants, payload types and coefficient tables for the Fresnel integral pipeline.
// Depends on nothing; every other file in rtl imports it.
package fres_pkg;

    localparam int ARG_WIDTH    = 32;
    localparam int RESULT_WIDTH = 32;

    localparam int DIV_AB_BITS   = 48;
    localparam int DIV_CD_BITS   = 30;
    localparam int CORDIC_STEPS  = 30;
    localparam int HORNER_STEPS  = 6;
    localparam int ROT_WIDTH     = 34;

    localparam logic [29:0] K_SQRT_2_OVER_PI = 30'd856722024;
    localparam logic [30:0] K_SQRT_PI_OVER_2 = 31'd1345735808;
    localparam logic [30:0] K_HALF_PI        = 31'd1686629713;
    localparam logic [29:0] K_SQRT_PI_OVER_8 = 30'd672867904;
    localparam logic [29:0] K_CORDIC_GAIN    = 30'd652032874;

    // Lanes of the polynomial bank.
    localparam logic [1:0] LANE_A = 2'd0;
    localparam logic [1:0] LANE_B = 2'd1;
    localparam logic [1:0] LANE_C = 2'd2;
    localparam logic [1:0] LANE_D = 2'd3;

    // Side information that travels with a word through the polynomial stages.
    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [31:0] t;
        logic [61:0] tt;
    } fres_side_t;

    // State of both long divisions for one word.
    typedef struct packed {
        logic                   neg;
        logic                   zero;
        logic [61:0]            tt;
        logic [63:0]            r_ab;
        logic [63:0]            b;
        logic [DIV_AB_BITS-1:0] q_ab;
        logic [63:0]            r_cd;
        logic [63:0]            d;
        logic [DIV_CD_BITS-1:0] q_cd;
    } fres_div_t;

    // State of the rotation for one word.
    typedef struct packed {
        logic                        neg;
        logic                        zero;
        logic [1:0]                  quad;
        logic [31:0]                 amp;
        logic signed [ROT_WIDTH-1:0] x;
        logic signed [ROT_WIDTH-1:0] y;
        logic signed [ROT_WIDTH-1:0] z;
    } fres_rot_t;

    // Polynomial coefficients in units of 1e-8; shorter polynomials are padded with zeros.
    function automatic logic [31:0] fres_coef(input logic [1:0] lane, input logic [2:0] k);
        logic [31:0] c;
        c = 32'd0;
        case (lane)
            LANE_A:
                case (k)
                    3'd0: c = 32'd100000000;
                    3'd1: c = 32'd19451610;
                    3'd2: c = 32'd23636410;
                    3'd3: c = 32'd6832400;
                    3'd4: c = 32'd2412120;
                    default: c = 32'd0;
                endcase
            LANE_B:
                case (k)
                    3'd0: c = 32'd200000000;
                    3'd1: c = 32'd293550410;
                    3'd2: c = 32'd275704600;
                    3'd3: c = 32'd187572100;
                    3'd4: c = 32'd97811300;
                    3'd5: c = 32'd35668100;
                    3'd6: c = 32'd11824700;
                    default: c = 32'd0;
                endcase
            LANE_C:
                case (k)
                    3'd0: c = 32'd100000000;
                    3'd1: c = 32'd77695070;
                    3'd2: c = 32'd64601170;
                    3'd3: c = 32'd34605090;
                    3'd4: c = 32'd13392590;
                    3'd5: c = 32'd4339950;
                    default: c = 32'd0;
                endcase
            default:
                case (k)
                    3'd0: c = 32'd141421356;
                    3'd1: c = 32'd251298060;
                    3'd2: c = 32'd271967410;
                    3'd3: c = 32'd198405240;
                    3'd4: c = 32'd109173250;
                    3'd5: c = 32'd42052170;
                    3'd6: c = 32'd13634704;
                    default: c = 32'd0;
                endcase
        endcase
        return c;
    endfunction

    // Arctangent of 2^-i in radians, Q.30.
    function automatic logic [31:0] fres_atan(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:  a = 32'h3243F6A8;
            5'd1:  a = 32'h1DAC6705;
            5'd2:  a = 32'h0FADBAFC;
            5'd3:  a = 32'h07F56EA6;
            5'd4:  a = 32'h03FEAB76;
            5'd5:  a = 32'h01FFD55B;
            5'd6:  a = 32'h00FFFAAA;
            5'd7:  a = 32'h007FFF55;
            5'd8:  a = 32'h003FFFEA;
            5'd9:  a = 32'h001FFFFD;
            5'd10: a = 32'h000FFFFF;
            5'd11: a = 32'h0007FFFF;
            5'd12: a = 32'h0003FFFF;
            5'd13: a = 32'h0001FFFF;
            5'd14: a = 32'h0000FFFF;
            5'd15: a = 32'h00007FFF;
            5'd16: a = 32'h00003FFF;
            5'd17: a = 32'h00001FFF;
            5'd18: a = 32'h00000FFF;
            5'd19: a = 32'h000007FF;
            5'd20: a = 32'h000003FF;
            5'd21: a = 32'h000001FF;
            5'd22: a = 32'h000000FF;
            5'd23: a = 32'h0000007F;
            5'd24: a = 32'h0000003F;
            5'd25: a = 32'h0000001F;
            5'd26: a = 32'h0000000F;
            5'd27: a = 32'h00000008;
            5'd28: a = 32'h00000004;
            5'd29: a = 32'h00000002;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/fres_horner_step.sv
// One Horner step for all four polynomials: split 64x32 products, then round, shift and add.
// Depends on fres_pkg.
module fres_horner_step import fres_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  fres_side_t       in_side,
    input  logic [3:0][63:0] in_acc,
    input  logic [2:0]       coef_idx,
    output logic             out_valid,
    output fres_side_t       out_side,
    output logic [3:0][63:0] out_acc
);

    logic             mul_valid_reg;
    fres_side_t       mul_side_reg;
    logic [3:0][63:0] pp_lo_reg;
    logic [3:0][63:0] pp_hi_reg;
    logic [3:0][63:0] pp_lo_next;
    logic [3:0][63:0] pp_hi_next;
    logic [3:0][95:0] sum_next;
    logic [3:0][63:0] acc_next;
    logic             acc_valid_reg;
    fres_side_t       acc_side_reg;
    logic [3:0][63:0] acc_reg;

    // Partial products of each accumulator half with t.
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            pp_lo_next[l] = 64'(in_acc[l][31:0]) * 64'(in_side.t);
            pp_hi_next[l] = 64'(in_acc[l][63:32]) * 64'(in_side.t);
        end
    end

    // Recombine, round to Q.24 and add the next coefficient, modulo 2^64.
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            sum_next[l] = {pp_hi_reg[l], 32'd0} + {32'd0, pp_lo_reg[l]} + 96'h80_0000;
            acc_next[l] = sum_next[l][87:24] + 64'(fres_coef(2'(l), coef_idx));
        end
    end

    // Valid bits of both internal stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            acc_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= in_valid;
            acc_valid_reg <= mul_valid_reg;
        end
    end

    // Payload of both internal stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_side_reg <= in_side;
            pp_lo_reg    <= pp_lo_next;
            pp_hi_reg    <= pp_hi_next;
            acc_side_reg <= mul_side_reg;
            acc_reg      <= acc_next;
        end
    end

    assign out_valid = acc_valid_reg;
    assign out_side  = acc_side_reg;
    assign out_acc   = acc_reg;

endmodule

FILE: rtl/fres_div_step.sv
// One restoring division step for a/b and, while enabled, for c/d.
// Depends on fres_pkg.
module fres_div_step import fres_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      cd_on,
    input  logic      in_valid,
    input  fres_div_t in_div,
    output logic      out_valid,
    output fres_div_t out_div
);

    logic      valid_reg;
    fres_div_t div_reg;
    fres_div_t div_next;
    logic [64:0] r2_ab;
    logic [64:0] r2_cd;
    logic [64:0] diff_ab;
    logic [64:0] diff_cd;
    logic        ge_ab;
    logic        ge_cd;

    // Double the remainder and subtract the divisor where it fits.
    always_comb
    begin
        r2_ab   = {in_div.r_ab, 1'b0};
        r2_cd   = {in_div.r_cd, 1'b0};
        diff_ab = r2_ab - {1'b0, in_div.b};
        diff_cd = r2_cd - {1'b0, in_div.d};
        ge_ab   = !diff_ab[64];
        ge_cd   = !diff_cd[64];
        div_next = in_div;
        div_next.r_ab = ge_ab ? diff_ab[63:0] : r2_ab[63:0];
        div_next.q_ab = {in_div.q_ab[DIV_AB_BITS-2:0], ge_ab};
        if (cd_on)
        begin
            div_next.r_cd = ge_cd ? diff_cd[63:0] : r2_cd[63:0];
            div_next.q_cd = {in_div.q_cd[DIV_CD_BITS-2:0], ge_cd};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;

endmodule

FILE: rtl/fres_cordic_step.sv
// One CORDIC rotation step in rotation mode, with floor shifts.
// Depends on fres_pkg.
module fres_cordic_step import fres_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic [4:0] step_idx,
    input  logic      in_valid,
    input  fres_rot_t in_rot,
    output logic      out_valid,
    output fres_rot_t out_rot
);

    logic      valid_reg;
    fres_rot_t rot_reg;
    fres_rot_t rot_next;
    logic signed [ROT_WIDTH-1:0] dx;
    logic signed [ROT_WIDTH-1:0] dy;
    logic signed [ROT_WIDTH-1:0] angle;

    // Rotate toward zero residual angle.
    always_comb
    begin
        dx    = in_rot.y >>> step_idx;
        dy    = in_rot.x >>> step_idx;
        angle = $signed({2'b00, fres_atan(step_idx)});
        rot_next = in_rot;
        if (!in_rot.z[ROT_WIDTH-1])
        begin
            rot_next.x = in_rot.x - dx;
            rot_next.y = in_rot.y + dy;
            rot_next.z = in_rot.z - angle;
        end
        else
        begin
            rot_next.x = in_rot.x + dx;
            rot_next.y = in_rot.y - dy;
            rot_next.z = in_rot.z + angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rot   = rot_reg;

endmodule

FILE: rtl/fres_skid.sv
// Two-entry output buffer that parts the pipeline from the result handshake.
// Depends on fres_pkg; room is decoded from the registered fill level.
module fres_skid import fres_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [RESULT_WIDTH-1:0] in_cos,
    input  logic signed [RESULT_WIDTH-1:0] in_sin,
    output logic                           room,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [RESULT_WIDTH-1:0] out_cos,
    output logic signed [RESULT_WIDTH-1:0] out_sin
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic signed [RESULT_WIDTH-1:0] cos0_reg, sin0_reg, cos1_reg, sin1_reg;
    logic push;
    logic pop;
    logic load_head;

    assign push      = in_valid;
    assign pop       = (count_reg != 2'd0) && out_ready;
    assign room      = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cos   = cos0_reg;
    assign out_sin   = sin0_reg;

    // A new word goes straight to the head when the head is empty or is leaving.
    assign load_head = push && ((count_reg == 2'd0) || ((count_reg == 2'd1) && pop));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Head and second slot; a word is pushed only while there is room.
    always_ff @(posedge clk)
    begin
        if (load_head)
        begin
            cos0_reg <= in_cos;
            sin0_reg <= in_sin;
        end
        else if (pop)
        begin
            cos0_reg <= cos1_reg;
            sin0_reg <= sin1_reg;
        end
        if (push && !load_head)
        begin
            cos1_reg <= in_cos;
            sin1_reg <= in_sin;
        end
    end

endmodule

FILE: rtl/fresnel_integral_rational.sv
// Fresnel cosine and sine integrals, C(x) and S(x), from a Q7.24 argument to Q1.30 results.
// Depends on fres_pkg, fres_horner_step, fres_div_step, fres_cordic_step and fres_skid.
//
// The block accepts one argument word per clock cycle and returns one result word for each,
// in order. A word passes through these stages: input and scaling (4), six Horner steps of
// two stages each (12), a 48-stage bit-per-stage divider that also forms c/d in its first 30
// stages (48), phase and amplitude scaling (3), 30 CORDIC stages (30), output arithmetic (4)
// and the output buffer (1). The whole pipeline advances together; it stalls only when both
// entries of the output buffer hold words that have not been taken.
module fresnel_integral_rational import fres_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           argument_valid,
    output logic                           argument_ready,
    input  logic signed [ARG_WIDTH-1:0]    argument,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic signed [RESULT_WIDTH-1:0] cosine_integral,
    output logic signed [RESULT_WIDTH-1:0] sine_integral
);

    typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

    logic en;
    logic room;

    // Input stage: sign, zero test and magnitude.
    logic        s0_valid_reg;
    logic        s0_neg_reg;
    logic        s0_zero_reg;
    logic [31:0] s0_mag_reg;
    logic [31:0] mag_next;

    // Scaling by sqrt(2/pi).
    logic        s1_valid_reg;
    logic        s1_neg_reg;
    logic        s1_zero_reg;
    logic [61:0] s1_prod_reg;
    logic [62:0] t_sum_next;
    logic        s2_valid_reg;
    logic        s2_neg_reg;
    logic        s2_zero_reg;
    logic [31:0] s2_t_reg;
    logic        s3_valid_reg;
    fres_side_t  s3_side_reg;

    // Horner chain.
    logic             hs_valid [0:HORNER_STEPS];
    fres_side_t       hs_side  [0:HORNER_STEPS];
    logic [3:0][63:0] hs_acc   [0:HORNER_STEPS];

    // Division chain.
    logic      dv_valid [0:DIV_AB_BITS];
    fres_div_t dv       [0:DIV_AB_BITS];

    // Phase and amplitude scaling.
    logic        p1_valid_reg;
    logic        p1_neg_reg;
    logic        p1_zero_reg;
    logic [49:0] p1_v_reg;
    logic [29:0] p1_ratio_reg;
    logic        p2_valid_reg;
    logic        p2_neg_reg;
    logic        p2_zero_reg;
    logic [1:0]  p2_quad_reg;
    logic [60:0] p2_pz_reg;
    logic [60:0] p2_pa_reg;
    logic [61:0] z_sum_next;
    logic [61:0] a_sum_next;
    logic        p3_valid_reg;
    fres_rot_t   p3_rot_reg;

    // CORDIC chain.
    logic      cr_valid [0:CORDIC_STEPS];
    fres_rot_t cr       [0:CORDIC_STEPS];

    // Output arithmetic.
    logic                        f1_valid_reg;
    logic                        f1_neg_reg;
    logic                        f1_zero_reg;
    logic [31:0]                 f1_amp_reg;
    logic signed [ROT_WIDTH-1:0] f1_cos_reg;
    logic signed [ROT_WIDTH-1:0] f1_sin_reg;
    logic signed [ROT_WIDTH-1:0] cos_next;
    logic signed [ROT_WIDTH-1:0] sin_next;
    logic                        f2_valid_reg;
    logic                        f2_neg_reg;
    logic                        f2_zero_reg;
    logic signed [66:0]          f2_pc_reg;
    logic signed [66:0]          f2_ps_reg;
    logic signed [66:0]          pc_round_next;
    logic signed [66:0]          ps_round_next;
    logic signed [37:0]          cval_next;
    logic signed [37:0]          sval_next;
    logic                        f3_valid_reg;
    logic                        f3_neg_reg;
    logic                        f3_zero_reg;
    logic signed [37:0]          f3_cval_reg;
    logic signed [37:0]          f3_sval_reg;
    logic signed [38:0]          cneg_next;
    logic signed [38:0]          sneg_next;
    logic signed [RESULT_WIDTH-1:0] csat_next;
    logic signed [RESULT_WIDTH-1:0] ssat_next;
    logic                           f4_valid_reg;
    logic signed [RESULT_WIDTH-1:0] f4_cos_reg;
    logic signed [RESULT_WIDTH-1:0] f4_sin_reg;

    localparam logic signed [38:0] SAT_TOP = 39'sd2147483647;
    localparam logic signed [38:0] SAT_BOTTOM = -39'sd2147483648;

    // The pipeline moves as one whenever the output buffer has room.
    assign en             = room;
    assign argument_ready = en;

    // Magnitude of the argument; the most negative value keeps its own pattern.
    assign mag_next   = argument[ARG_WIDTH-1] ? 32'(-argument) : 32'(argument);
    assign t_sum_next = {1'b0, s1_prod_reg} + 63'h2000_0000;

    // Valid bits of the stages kept in this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= argument_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            p1_valid_reg <= dv_valid[DIV_AB_BITS];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            f1_valid_reg <= cr_valid[CORDIC_STEPS];
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
        end
    end

    // Front stages: magnitude, scaling to t, and t squared.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_neg_reg  <= argument[ARG_WIDTH-1];
            s0_zero_reg <= (argument == '0);
            s0_mag_reg  <= mag_next;
            s1_neg_reg  <= s0_neg_reg;
            s1_zero_reg <= s0_zero_reg;
            s1_prod_reg <= 62'(s0_mag_reg) * 62'(K_SQRT_2_OVER_PI);
            s2_neg_reg  <= s1_neg_reg;
            s2_zero_reg <= s1_zero_reg;
            s2_t_reg    <= t_sum_next[61:30];
            s3_side_reg.neg  <= s2_neg_reg;
            s3_side_reg.zero <= s2_zero_reg;
            s3_side_reg.t    <= s2_t_reg;
            s3_side_reg.tt   <= 62'(s2_t_reg) * 62'(s2_t_reg);
        end
    end

    // Horner bank, starting from the leading coefficients.
    assign hs_valid[0] = s3_valid_reg;
    assign hs_side[0]  = s3_side_reg;
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            hs_acc[0][l] = 64'(fres_coef(2'(l), 3'd6));
        end
    end

    for (genvar j = 0; j < HORNER_STEPS; j++)
    begin : g_horner
        fres_horner_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (hs_valid[j]),
            .in_side   (hs_side[j]),
            .in_acc    (hs_acc[j]),
            .coef_idx  (3'(HORNER_STEPS - 1 - j)),
            .out_valid (hs_valid[j+1]),
            .out_side  (hs_side[j+1]),
            .out_acc   (hs_acc[j+1])
        );
    end

    // Both ratios are below one, so the remainders start at the numerators.
    assign dv_valid[0]  = hs_valid[HORNER_STEPS];
    assign dv[0].neg    = hs_side[HORNER_STEPS].neg;
    assign dv[0].zero   = hs_side[HORNER_STEPS].zero;
    assign dv[0].tt     = hs_side[HORNER_STEPS].tt;
    assign dv[0].r_ab   = hs_acc[HORNER_STEPS][LANE_A];
    assign dv[0].b      = hs_acc[HORNER_STEPS][LANE_B];
    assign dv[0].q_ab   = '0;
    assign dv[0].r_cd   = hs_acc[HORNER_STEPS][LANE_C];
    assign dv[0].d      = hs_acc[HORNER_STEPS][LANE_D];
    assign dv[0].q_cd   = '0;

    for (genvar j = 0; j < DIV_AB_BITS; j++)
    begin : g_div
        fres_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .cd_on     ((j < DIV_CD_BITS) ? 1'b1 : 1'b0),
            .in_valid  (dv_valid[j]),
            .in_div    (dv[j]),
            .out_valid (dv_valid[j+1]),
            .out_div   (dv[j+1])
        );
    end

    assign z_sum_next = {1'b0, p2_pz_reg} + 62'h2000_0000;
    assign a_sum_next = {1'b0, p2_pa_reg} + 62'h2000_0000;

    // Phase in quarter turns, then conversion to radians and the amplitude.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_neg_reg   <= dv[DIV_AB_BITS].neg;
            p1_zero_reg  <= dv[DIV_AB_BITS].zero;
            p1_v_reg     <= {2'b00, dv[DIV_AB_BITS].q_ab} - dv[DIV_AB_BITS].tt[49:0];
            p1_ratio_reg <= dv[DIV_AB_BITS].q_cd;
            p2_neg_reg   <= p1_neg_reg;
            p2_zero_reg  <= p1_zero_reg;
            p2_quad_reg  <= p1_v_reg[49:48];
            p2_pz_reg    <= 61'(p1_v_reg[47:18]) * 61'(K_HALF_PI);
            p2_pa_reg    <= 61'(p1_ratio_reg) * 61'(K_SQRT_PI_OVER_2);
            p3_rot_reg.neg  <= p2_neg_reg;
            p3_rot_reg.zero <= p2_zero_reg;
            p3_rot_reg.quad <= p2_quad_reg;
            p3_rot_reg.amp  <= a_sum_next[61:30];
            p3_rot_reg.x    <= $signed(ROT_WIDTH'(K_CORDIC_GAIN));
            p3_rot_reg.y    <= '0;
            p3_rot_reg.z    <= $signed(ROT_WIDTH'(z_sum_next[61:30]));
        end
    end

    assign cr_valid[0] = p3_valid_reg;
    assign cr[0]       = p3_rot_reg;

    for (genvar j = 0; j < CORDIC_STEPS; j++)
    begin : g_cordic
        fres_cordic_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step_idx  (5'(j)),
            .in_valid  (cr_valid[j]),
            .in_rot    (cr[j]),
            .out_valid (cr_valid[j+1]),
            .out_rot   (cr[j+1])
        );
    end

    // Quadrant correction of the rotated vector.
    always_comb
    begin
        case (quad_t'(cr[CORDIC_STEPS].quad))
            QUAD_I:
            begin
                cos_next = cr[CORDIC_STEPS].x;
                sin_next = cr[CORDIC_STEPS].y;
            end
            QUAD_II:
            begin
                cos_next = -cr[CORDIC_STEPS].y;
                sin_next = cr[CORDIC_STEPS].x;
            end
            QUAD_III:
            begin
                cos_next = -cr[CORDIC_STEPS].x;
                sin_next = -cr[CORDIC_STEPS].y;
            end
            default:
            begin
                cos_next = cr[CORDIC_STEPS].y;
                sin_next = -cr[CORDIC_STEPS].x;
            end
        endcase
    end

    // Rounded products, subtraction from sqrt(pi/8), sign and saturation.
    always_comb
    begin
        pc_round_next = f2_pc_reg + 67'sh2000_0000;
        ps_round_next = f2_ps_reg + 67'sh2000_0000;
        cval_next = $signed({8'd0, K_SQRT_PI_OVER_8}) - 38'(pc_round_next >>> 30);
        sval_next = $signed({8'd0, K_SQRT_PI_OVER_8}) - 38'(ps_round_next >>> 30);
        cneg_next = f3_neg_reg ? -39'(f3_cval_reg) : 39'(f3_cval_reg);
        sneg_next = f3_neg_reg ? -39'(f3_sval_reg) : 39'(f3_sval_reg);
        if (cneg_next > SAT_TOP)
        begin
            csat_next = SAT_TOP[RESULT_WIDTH-1:0];
        end
        else if (cneg_next < SAT_BOTTOM)
        begin
            csat_next = SAT_BOTTOM[RESULT_WIDTH-1:0];
        end
        else
        begin
            csat_next = cneg_next[RESULT_WIDTH-1:0];
        end
        if (sneg_next > SAT_TOP)
        begin
            ssat_next = SAT_TOP[RESULT_WIDTH-1:0];
        end
        else if (sneg_next < SAT_BOTTOM)
        begin
            ssat_next = SAT_BOTTOM[RESULT_WIDTH-1:0];
        end
        else
        begin
            ssat_next = sneg_next[RESULT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_neg_reg  <= cr[CORDIC_STEPS].neg;
            f1_zero_reg <= cr[CORDIC_STEPS].zero;
            f1_amp_reg  <= cr[CORDIC_STEPS].amp;
            f1_cos_reg  <= cos_next;
            f1_sin_reg  <= sin_next;
            f2_neg_reg  <= f1_neg_reg;
            f2_zero_reg <= f1_zero_reg;
            f2_pc_reg   <= 67'($signed({1'b0, f1_amp_reg})) * 67'(f1_sin_reg);
            f2_ps_reg   <= 67'($signed({1'b0, f1_amp_reg})) * 67'(f1_cos_reg);
            f3_neg_reg  <= f2_neg_reg;
            f3_zero_reg <= f2_zero_reg;
            f3_cval_reg <= cval_next;
            f3_sval_reg <= sval_next;
            f4_cos_reg  <= f3_zero_reg ? '0 : csat_next;
            f4_sin_reg  <= f3_zero_reg ? '0 : ssat_next;
        end
    end

    fres_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f4_valid_reg && en),
        .in_cos    (f4_cos_reg),
        .in_sin    (f4_sin_reg),
        .room      (room),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_cos   (cosine_integral),
        .out_sin   (sine_integral)
    );

    // The input side stalls only while the output buffer is full of untaken words.
    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !argument_ready |-> result_valid)
        else $error("input stalled with no result waiting");

    // A full buffer that is not drained stays full.
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!argument_ready && !result_ready) |=> !argument_ready)
        else $error("output buffer left the full state without a pop");

    // A finished word held by a stall is still there next cycle.
    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (f4_valid_reg && !en) |=> (f4_valid_reg && $stable(f4_cos_reg) && $stable(f4_sin_reg)))
        else $error("last pipeline stage changed during a stall");

endmodule

FILE: verif/tb_fresnel_integral_rational.sv
// Testbench for fresnel_integral_rational: directed and random arguments over valid/ready.
// Depends on fres_pkg and the RTL of fresnel_integral_rational; results are predicted in place.
`timescale 1ns / 100ps

module tb_fresnel_integral_rational import fres_pkg::*; ();

    typedef struct {
        logic signed [RESULT_WIDTH-1:0] cosv;
        logic signed [RESULT_WIDTH-1:0] sinv;
    } fresnel_pair_t;

    typedef struct {
        logic signed [ARG_WIDTH-1:0]    arg;
        bit                             typed;
        logic signed [RESULT_WIDTH-1:0] cosv;
        logic signed [RESULT_WIDTH-1:0] sinv;
    } stim_row_t;

    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 150;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           argument_valid = 1'b0;
    logic                           argument_ready;
    logic signed [ARG_WIDTH-1:0]    argument = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    logic signed [RESULT_WIDTH-1:0] cosine_integral;
    logic signed [RESULT_WIDTH-1:0] sine_integral;

    fresnel_pair_t pending_results[$];
    int            error_count = 0;
    bit            burst_send = 1'b0;
    bit            burst_take = 1'b0;
    stim_row_t     directed_rows[16];

    fresnel_integral_rational u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .argument_valid (argument_valid),
        .argument_ready (argument_ready),
        .argument       (argument),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .cosine_integral(cosine_integral),
        .sine_integral  (sine_integral)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Rounded product scaled down by 2^sh, kept to 64 bits.
    function automatic longint unsigned scale_round(longint unsigned p, longint unsigned q,
                                                    int sh);
        logic [127:0] prod;
        prod = 128'(p) * 128'(q);
        prod = prod + (128'd1 << (sh - 1));
        prod = prod >> sh;
        return prod[63:0];
    endfunction

    function automatic longint unsigned eval_poly(logic [1:0] lane, int deg,
                                                  longint unsigned t);
        longint unsigned acc;
        acc = fres_coef_copy(lane, deg);
        for (int k = deg - 1; k >= 0; k--)
            acc = scale_round(acc, t, 24) + fres_coef_copy(lane, k);
        return acc;
    endfunction

    // Coefficients in units of 1e-8.
    function automatic longint unsigned fres_coef_copy(logic [1:0] lane, int k);
        longint unsigned ca[5] = '{100000000, 19451610, 23636410, 6832400, 2412120};
        longint unsigned cb[7] = '{200000000, 293550410, 275704600, 187572100, 97811300,
                                   35668100, 11824700};
        longint unsigned cc[6] = '{100000000, 77695070, 64601170, 34605090, 13392590,
                                   4339950};
        longint unsigned cd[7] = '{141421356, 251298060, 271967410, 198405240, 109173250,
                                   42052170, 13634704};
        case (lane)
            LANE_A:  return ca[k];
            LANE_B:  return cb[k];
            LANE_C:  return cc[k];
            default: return cd[k];
        endcase
    endfunction

    // Truncated quotient with the given number of fraction bits.
    function automatic longint unsigned frac_quotient(longint unsigned n, longint unsigned d,
                                                      int bits);
        longint unsigned q;
        longint unsigned r;
        if (d == 0)
            return 0;
        q = n / d;
        r = n % d;
        for (int i = 0; i < bits; i++)
        begin
            q = q << 1;
            if (r >= d - r)
            begin
                r = r - (d - r);
                q = q | 64'd1;
            end
            else
                r = r << 1;
        end
        return q;
    endfunction

    function automatic longint clamp_result(longint v);
        longint top;
        top = (64'sd1 <<< (RESULT_WIDTH - 1)) - 1;
        if (v > top)
            return top;
        if (v < -top - 1)
            return -top - 1;
        return v;
    endfunction

    function automatic fresnel_pair_t predict_fresnel(logic signed [ARG_WIDTH-1:0] x_in);
        fresnel_pair_t   res;
        longint unsigned mag, t, pa, pb, pc, pd, v, f, ratio, amp;
        longint          x, y, z, dx, dy, cs, sn, cosv, sinv, cval, sval;
        logic [1:0]      quad;
        logic [31:0]     at;
        bit              neg;
        neg = x_in[ARG_WIDTH-1];
        if (x_in == 0)
        begin
            res.cosv = '0;
            res.sinv = '0;
            return res;
        end
        mag = neg ? (64'd1 << ARG_WIDTH) - 64'(unsigned'(x_in)) : 64'(unsigned'(x_in));
        t  = scale_round(mag, 64'(K_SQRT_2_OVER_PI), 30);
        pa = eval_poly(LANE_A, 4, t);
        pb = eval_poly(LANE_B, 6, t);
        pc = eval_poly(LANE_C, 5, t);
        pd = eval_poly(LANE_D, 6, t);

        // Phase in quarter turns, reduced to four quadrants.
        v = (frac_quotient(pa, pb, 48) - t * t) & ((64'd1 << 50) - 1);
        quad = v[49:48];
        f = v & ((64'd1 << 48) - 1);
        z = longint'(scale_round(f >> 18, 64'(K_HALF_PI), 30));

        x = longint'(K_CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            at = fres_atan_copy(i);
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(at);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(at);
            end
        end
        cs = x;
        sn = y;
        case (quad)
            2'd0:
            begin
                cosv = cs;
                sinv = sn;
            end
            2'd1:
            begin
                cosv = -sn;
                sinv = cs;
            end
            2'd2:
            begin
                cosv = -cs;
                sinv = -sn;
            end
            default:
            begin
                cosv = sn;
                sinv = -cs;
            end
        endcase

        ratio = frac_quotient(pc, pd, 30) & 64'hFFFF_FFFF;
        amp = scale_round(ratio, 64'(K_SQRT_PI_OVER_2), 30) & 64'hFFFF_FFFF;
        cval = longint'(K_SQRT_PI_OVER_8) - ((longint'(amp) * sinv + (64'sd1 <<< 29)) >>> 30);
        sval = longint'(K_SQRT_PI_OVER_8) - ((longint'(amp) * cosv + (64'sd1 <<< 29)) >>> 30);
        if (neg)
        begin
            cval = -cval;
            sval = -sval;
        end
        res.cosv = RESULT_WIDTH'(clamp_result(cval));
        res.sinv = RESULT_WIDTH'(clamp_result(sval));
        return res;
    endfunction

    // Arctangent of 2^-i, Q.30.
    function automatic logic [31:0] fres_atan_copy(int i);
        logic [31:0] tab[30] = '{
            32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
            32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
            32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
            32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
            32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
            32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002};
        return tab[i];
    endfunction

    function automatic logic signed [ARG_WIDTH-1:0] draw_argument();
        logic signed [ARG_WIDTH-1:0] a;
        int                          pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            a = $urandom;
        else if (pick < 8)
            a = $urandom_range(0, 32'h0800_0000);
        else
            a = $urandom_range(0, 32'h0000_0400);
        if (pick >= 5 && $urandom_range(0, 1))
            a = -a;
        return a;
    endfunction

    // Drives one argument word and returns once it has been accepted.
    task automatic send_word(logic signed [ARG_WIDTH-1:0] a, bit typed,
                             fresnel_pair_t typed_res);
        int gap;
        gap = burst_send ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            argument_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        argument_valid <= 1'b1;
        argument <= a;
        @(posedge clk);
        while (!argument_ready)
            @(posedge clk);
        pending_results.push_back(typed ? typed_res : predict_fresnel(a));
    endtask

    // Stimulus: directed table, then random arguments.
    initial
    begin
        fresnel_pair_t typed_res;
        directed_rows[0]  = '{32'sd0, 1'b1, 32'sd0, 32'sd0};
        directed_rows[1]  = '{32'sd1, 1'b0, 0, 0};
        directed_rows[2]  = '{-32'sd1, 1'b0, 0, 0};
        directed_rows[3]  = '{32'h7FFF_FFFF, 1'b0, 0, 0};
        directed_rows[4]  = '{32'h8000_0000, 1'b0, 0, 0};
        directed_rows[5]  = '{32'h8000_0001, 1'b0, 0, 0};
        directed_rows[6]  = '{32'h0100_0000, 1'b0, 0, 0};
        directed_rows[7]  = '{32'hFF00_0000, 1'b0, 0, 0};
        directed_rows[8]  = '{32'h0080_0000, 1'b0, 0, 0};
        directed_rows[9]  = '{32'h0200_0000, 1'b0, 0, 0};
        directed_rows[10] = '{32'h0A00_0000, 1'b0, 0, 0};
        directed_rows[11] = '{32'h4000_0000, 1'b0, 0, 0};
        directed_rows[12] = '{32'hAAAA_AAAA, 1'b0, 0, 0};
        directed_rows[13] = '{32'h5555_5555, 1'b0, 0, 0};
        directed_rows[14] = '{32'sd0, 1'b1, 32'sd0, 32'sd0};
        directed_rows[15] = '{32'h0000_0100, 1'b0, 0, 0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_res.cosv = directed_rows[i].cosv;
            typed_res.sinv = directed_rows[i].sinv;
            send_word(directed_rows[i].arg, directed_rows[i].typed, typed_res);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Back-to-back stretches on both sides now and then.
            if (n % 250 == 0)
            begin
                burst_send = ($urandom_range(0, 3) == 0);
                burst_take = ($urandom_range(0, 3) == 0);
            end
            send_word(draw_argument(), 1'b0, typed_res);
        end
        argument_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result side: stalls between words, and takes each word when it is offered.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = burst_take ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        fresnel_pair_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word C=%h S=%h", $realtime,
                         cosine_integral, sine_integral);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (cosine_integral !== want.cosv)
                begin
                    $display("%0t: cosine_integral expected %h actual %h", $realtime,
                             want.cosv, cosine_integral);
                    error_count++;
                end
                if (sine_integral !== want.sinv)
                begin
                    $display("%0t: sine_integral expected %h actual %h", $realtime,
                             want.sinv, sine_integral);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
